// ===== rtl/pfp_pkg.sv =====
// Shared types, constants and helpers for the polyline projection block.
package pfp_pkg;

   localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;
   localparam int unsigned TOL_W = 10;

   typedef struct packed {
      logic        [33:0] len;
      logic        [31:0] st;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } vtx_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APP_MX,
      ST_APP_MY,
      ST_APP_SQ,
      ST_Q_RD0,
      ST_Q_LD0,
      ST_Q_RD,
      ST_Q_LD,
      ST_Q_CHK,
      ST_M_DXPX,
      ST_M_DYPY,
      ST_D_DOT,
      ST_M_DXPY,
      ST_M_DYPX,
      ST_D_CRS,
      ST_M_SQA,
      ST_M_SQB,
      ST_CMP,
      ST_NEXT,
      ST_FIN_SQ,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      RG_START,
      RG_END,
      RG_FOOT
   } region_type;

   function automatic logic [35:0] mag_of(input logic signed [36:0] v);
      logic signed [36:0] n;
      n = -v;
      return v[36] ? n[35:0] : v[35:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [38:0] v);
      if (v > 39'(SAT_HI)) begin
         return SAT_HI;
      end else if (v < 39'(SAT_LO)) begin
         return SAT_LO;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/pfp_vtx_mem.sv =====
// Vertex memory: coordinates, running station and incoming segment length.
module pfp_vtx_mem
   import pfp_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  vtx_type       wdata,
   input  logic [AW-1:0] raddr,
   output vtx_type       rdata
);

   vtx_type mem [DEPTH];
   vtx_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pfp_mul.sv =====
// Two-pass 36x36 unsigned multiplier, 18 multiplier bits per pass.
module pfp_mul
   import pfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [35:0] a,
   input  logic [35:0] b,
   output logic        done,
   output logic [71:0] prod
);

   logic [35:0] a_ff, b_ff;
   logic [71:0] acc_ff;
   logic [1:0]  ph_ff;
   logic        done_ff;
   logic [53:0] pp;

   assign pp = (ph_ff == 2'd1) ? a_ff * b_ff[17:0] : a_ff * b_ff[35:18];

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (ph_ff == 2'd2);
         if (start) begin
            ph_ff <= 2'd1;
         end else if (ph_ff == 2'd1) begin
            ph_ff <= 2'd2;
         end else begin
            ph_ff <= 2'd0;
         end
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      if (ph_ff == 2'd1) begin
         acc_ff <= 72'(pp);
      end else if (ph_ff == 2'd2) begin
         acc_ff <= acc_ff + {pp, 18'b0};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/pfp_div.sv =====
// Restoring divider, one quotient bit per cycle, 36-bit quotient.
module pfp_div
   import pfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [71:0] num,
   input  logic [33:0] den,
   output logic        done,
   output logic [35:0] quot
);

   logic [36:0] rem_ff;
   logic [35:0] nlo_ff;
   logic [33:0] den_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [36:0] trial;
   logic        ge;

   assign trial = {rem_ff[35:0], nlo_ff[35]};
   assign ge    = trial >= {3'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 6'd1)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         rem_ff <= {1'b0, num[71:36]};
         nlo_ff <= num[35:0];
         den_ff <= den;
         cnt_ff <= 6'd36;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial - {3'b0, den_ff} : trial;
         nlo_ff <= {nlo_ff[34:0], ge};
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign quot = nlo_ff;

endmodule

// ===== rtl/pfp_sqrt.sv =====
// Digit-by-digit integer square root of a 72-bit radicand, one root bit per cycle.
module pfp_sqrt
   import pfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [71:0] rad,
   output logic        done,
   output logic [35:0] root
);

   logic [71:0] op_ff;
   logic [39:0] rem_ff;
   logic [35:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [39:0] trial_rem, trial;
   logic        ge;

   assign trial_rem = {rem_ff[37:0], op_ff[71:70]};
   assign trial     = {2'b0, root_ff, 2'b01};
   assign ge        = trial_rem >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 6'd1)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         op_ff   <= rad;
         rem_ff  <= 40'd0;
         root_ff <= 36'd0;
         cnt_ff  <= 6'd36;
      end else if (busy_ff) begin
         rem_ff  <= ge ? trial_rem - trial : trial_rem;
         root_ff <= {root_ff[34:0], ge};
         op_ff   <= {op_ff[69:0], 2'b00};
         cnt_ff  <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/polyline_frenet_projection.sv =====
// Polyline store and station/lateral projection, top level.
//
// Input items on req_: kind in tuser[0] selects append vertex (0) or query (1);
// start_new in tuser[1] clears the line before an append. x, y are Q.10.
// Results on rsp_, one per query item, none per append.
// csr_wr_en writes zero_length_tolerance (reset value 1); write only when idle.
// One item is processed at a time; req_tready is high only while idle.
// Append of the first vertex is written directly; append to a full store only
// sets the overflow flag; append of any other vertex takes two multiplies and a
// square root for the segment length. Query: each segment is read and checked
// against the zero-length tolerance; a kept segment is projected and compared
// with the best so far, and a final square root follows when one is kept.
// With fewer than two vertices a query goes straight to the result.
// A kept segment costs one memory read, five or six multiplies, two divides.
// Reset empties the line, clears the overflow flag and the output valid.
// A finished result sits in the rsp_ output register until taken; the block
// accepts further items meanwhile, and holds a later result back, taking no
// new items, until the pending one is taken.
module polyline_frenet_projection
   import pfp_pkg::*;
#(
   parameter int MAX_VERTICES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x[31:0], y[63:32]
   input  logic [1:0]  req_tuser,   // kind[0], start_new[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // station[31:0], lateral[63:32], segment_index[71:64]
   output logic [1:0]  rsp_tuser,   // ok[0], overflowed[1]
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   logic [CW-1:0]      count_ff;
   logic               ovf_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic signed [31:0] qx_ff, qy_ff, lastx_ff, lasty_ff;
   logic [31:0]        lastst_ff;
   logic signed [31:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [31:0]        st0_ff, st1_ff;
   logic [33:0]        len1_ff;
   logic [AW-1:0]      idx_ff;
   logic signed [73:0] acc_ff;
   logic signed [36:0] pq_ff, cq_ff;
   logic               found_ff, short_ff;
   logic [AW-1:0]      best_ff;
   logic [71:0]        bsq_ff;
   logic signed [36:0] bproj_ff, bprod_ff;
   logic [33:0]        blen_ff;
   logic [31:0]        bst_ff;
   logic [35:0]        dist_ff;

   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic req_acc, kind, start_new;
   logic [CW-1:0] count_eff;

   logic        mul_start, mul_done, div_start, div_done, sq_start, sq_done;
   logic [71:0] mul_prod;
   logic [35:0] div_quot, sq_root;
   logic [71:0] div_num, sq_rad;
   logic signed [36:0] opa, opb;
   logic signed [73:0] sp, absacc;
   logic        mul_neg;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   vtx_type       mem_wdata, mem_rdata;

   logic signed [33:0] adx, ady, dx, dy, px, py, ex, ey;
   region_type   region;
   logic [34:0]  stsum;
   logic [31:0]  stnew;
   logic         last_seg, better;
   logic signed [36:0] quot_s;

   logic               fin_first, fin_last, prod_pos;
   logic signed [38:0] pj, lw, stw, sd, latw, stres, latres;
   logic [AW+7:0]      best_w;
   logic               out_load;

   assign kind       = req_tuser[0];
   assign start_new  = req_tuser[1];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign count_eff  = start_new ? '0 : count_ff;

   assign adx = 34'(qx_ff) - 34'(lastx_ff);
   assign ady = 34'(qy_ff) - 34'(lasty_ff);
   assign dx  = 34'(x1_ff) - 34'(x0_ff);
   assign dy  = 34'(y1_ff) - 34'(y0_ff);
   assign px  = 34'(qx_ff) - 34'(x0_ff);
   assign py  = 34'(qy_ff) - 34'(y0_ff);
   assign ex  = 34'(qx_ff) - 34'(x1_ff);
   assign ey  = 34'(qy_ff) - 34'(y1_ff);

   always_comb begin
      if (pq_ff < 37'sd0) begin
         region = RG_START;
      end else if (pq_ff > $signed({3'b0, len1_ff})) begin
         region = RG_END;
      end else begin
         region = RG_FOOT;
      end
   end

   always_comb begin
      case (state_ff)
         ST_APP_MX: begin opa = 37'(adx); opb = 37'(adx); end
         ST_APP_MY: begin opa = 37'(ady); opb = 37'(ady); end
         ST_M_DXPX: begin opa = 37'(dx);  opb = 37'(px);  end
         ST_M_DYPY: begin opa = 37'(dy);  opb = 37'(py);  end
         ST_M_DXPY: begin opa = 37'(dx);  opb = 37'(py);  end
         ST_M_DYPX: begin opa = 37'(dy);  opb = 37'(px);  end
         ST_M_SQA: begin
            case (region)
               RG_START: begin opa = 37'(px); opb = 37'(px); end
               RG_END:   begin opa = 37'(ex); opb = 37'(ex); end
               default:  begin opa = cq_ff;   opb = cq_ff;   end
            endcase
         end
         ST_M_SQB: begin
            if (region == RG_START) begin
               opa = 37'(py); opb = 37'(py);
            end else begin
               opa = 37'(ey); opb = 37'(ey);
            end
         end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   assign mul_neg = opa[36] ^ opb[36];
   assign sp      = mul_neg ? -$signed({2'b0, mul_prod}) : $signed({2'b0, mul_prod});
   assign absacc  = acc_ff[73] ? -acc_ff : acc_ff;
   assign div_num = absacc[71:0];
   assign quot_s  = acc_ff[73] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign sq_rad  = (state_ff == ST_APP_SQ) ? acc_ff[71:0] : bsq_ff;

   assign stsum    = {3'b0, lastst_ff} + {1'b0, sq_root[33:0]};
   assign stnew    = (stsum > 35'h07FFF_FFFF) ? SAT_HI : stsum[31:0];
   assign last_seg = (CW'(idx_ff) + CW'(2)) == count_ff;
   assign better   = !found_ff || (acc_ff[71:0] < bsq_ff);

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      sq_start  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = '{len: sq_root[33:0], st: stnew, y: qy_ff, x: qx_ff};
      mem_raddr = AW'(idx_ff + 1'b1);
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (kind) begin
                  state_in = (count_ff < CW'(2)) ? ST_FIN : ST_Q_RD0;
               end else if (count_eff < CW'(MAX_VERTICES)) begin
                  if (count_eff == '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = '{len: '0, st: '0, y: req_tdata[63:32], x: req_tdata[31:0]};
                  end else begin
                     state_in = ST_APP_MX;
                  end
               end
            end
         end
         ST_APP_MX, ST_APP_MY, ST_M_DXPX, ST_M_DYPY, ST_M_DXPY, ST_M_DYPX,
         ST_M_SQA, ST_M_SQB: begin
            mul_start = !pend_ff;
            pend_in   = !pend_ff || !mul_done;
            if (pend_ff && mul_done) begin
               case (state_ff)
                  ST_APP_MX: state_in = ST_APP_MY;
                  ST_APP_MY: state_in = ST_APP_SQ;
                  ST_M_DXPX: state_in = ST_M_DYPY;
                  ST_M_DYPY: state_in = ST_D_DOT;
                  ST_M_DXPY: state_in = ST_M_DYPX;
                  ST_M_DYPX: state_in = ST_D_CRS;
                  ST_M_SQA:  state_in = (region == RG_FOOT) ? ST_CMP : ST_M_SQB;
                  default:   state_in = ST_CMP;
               endcase
            end
         end
         ST_D_DOT, ST_D_CRS: begin
            div_start = !pend_ff;
            pend_in   = !pend_ff || !div_done;
            if (pend_ff && div_done) begin
               state_in = (state_ff == ST_D_DOT) ? ST_M_DXPY : ST_M_SQA;
            end
         end
         ST_APP_SQ, ST_FIN_SQ: begin
            sq_start = !pend_ff;
            pend_in  = !pend_ff || !sq_done;
            if (pend_ff && sq_done) begin
               if (state_ff == ST_APP_SQ) begin
                  mem_we   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_Q_RD0: begin
            mem_raddr = '0;
            state_in  = ST_Q_LD0;
         end
         ST_Q_LD0: state_in = ST_Q_RD;
         ST_Q_RD:  state_in = ST_Q_LD;
         ST_Q_LD:  state_in = ST_Q_CHK;
         ST_Q_CHK: begin
            state_in = (len1_ff <= 34'(tol_ff)) ? ST_NEXT : ST_M_DXPX;
         end
         ST_CMP:   state_in = ST_NEXT;
         ST_NEXT: begin
            if (last_seg) begin
               state_in = found_ff ? ST_FIN_SQ : ST_FIN;
            end else begin
               state_in = ST_Q_RD;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         tol_ff       <= TOL_W'(1);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         short_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_acc) begin
            qx_ff <= req_tdata[31:0];
            qy_ff <= req_tdata[63:32];
            if (kind) begin
               short_ff <= count_ff < CW'(2);
               found_ff <= 1'b0;
            end else begin
               if (start_new) begin
                  ovf_ff <= 1'b0;
               end
               if (count_eff >= CW'(MAX_VERTICES)) begin
                  ovf_ff <= 1'b1;
               end else if (count_eff == '0) begin
                  count_ff  <= CW'(1);
                  lastx_ff  <= req_tdata[31:0];
                  lasty_ff  <= req_tdata[63:32];
                  lastst_ff <= '0;
               end
            end
         end
         if ((state_ff == ST_APP_SQ) && pend_ff && sq_done) begin
            count_ff  <= count_ff + CW'(1);
            lastx_ff  <= qx_ff;
            lasty_ff  <= qy_ff;
            lastst_ff <= stnew;
         end
         if ((state_ff == ST_CMP) && better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_Q_RD0: idx_ff <= '0;
         ST_Q_LD0: begin
            x0_ff  <= mem_rdata.x;
            y0_ff  <= mem_rdata.y;
            st0_ff <= mem_rdata.st;
         end
         ST_Q_LD: begin
            x1_ff   <= mem_rdata.x;
            y1_ff   <= mem_rdata.y;
            st1_ff  <= mem_rdata.st;
            len1_ff <= mem_rdata.len;
         end
         ST_NEXT: begin
            if (!last_seg) begin
               idx_ff <= idx_ff + 1'b1;
               x0_ff  <= x1_ff;
               y0_ff  <= y1_ff;
               st0_ff <= st1_ff;
            end
         end
         ST_CMP: begin
            if (better) begin
               best_ff  <= idx_ff;
               bsq_ff   <= acc_ff[71:0];
               bproj_ff <= pq_ff;
               bprod_ff <= cq_ff;
               blen_ff  <= len1_ff;
               bst_ff   <= st0_ff;
            end
         end
         default: ;
      endcase
      if (pend_ff && mul_done) begin
         case (state_ff)
            ST_APP_MX, ST_M_SQA:  acc_ff <= $signed({2'b0, mul_prod});
            ST_APP_MY, ST_M_SQB:  acc_ff <= acc_ff + $signed({2'b0, mul_prod});
            ST_M_DXPX, ST_M_DXPY: acc_ff <= sp;
            ST_M_DYPY:            acc_ff <= acc_ff + sp;
            ST_M_DYPX:            acc_ff <= acc_ff - sp;
            default: ;
         endcase
      end
      if (pend_ff && div_done) begin
         if (state_ff == ST_D_DOT) begin
            pq_ff <= quot_s;
         end else begin
            cq_ff <= quot_s;
         end
      end
      if ((state_ff == ST_FIN_SQ) && pend_ff && sq_done) begin
         dist_ff <= sq_root;
      end
      if (out_load) begin
         rsp_data_ff <= {(short_ff || !found_ff) ? 8'd0 : best_w[7:0],
                         short_ff ? 32'd0 : (found_ff ? sat32(latres) : SAT_LO),
                         (short_ff || !found_ff) ? 32'd0 : sat32(stres)};
         rsp_user_ff <= {ovf_ff, !short_ff};
      end
   end

   assign best_w    = (AW + 8)'(best_ff);
   assign fin_first = (best_ff == '0);
   assign fin_last  = (CW'(best_ff) + CW'(2)) == count_ff;
   assign prod_pos  = !bprod_ff[36] && (bprod_ff != '0);
   assign pj        = 39'(bproj_ff);
   assign lw        = $signed({5'b0, blen_ff});
   assign stw       = $signed({7'b0, bst_ff});
   assign sd        = prod_pos ? $signed({3'b0, dist_ff}) : -$signed({3'b0, dist_ff});
   assign latw      = 39'(bprod_ff);

   always_comb begin
      if (fin_first) begin
         stres  = (pj < lw) ? pj : lw;
         latres = (pj < 39'sd0) ? latw : sd;
      end else if (fin_last) begin
         stres  = stw + ((pj > 39'sd0) ? pj : 39'sd0);
         latres = (pj > 39'sd0) ? latw : sd;
      end else begin
         stres  = stw + ((pj < 39'sd0) ? 39'sd0 : ((pj > lw) ? lw : pj));
         latres = sd;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   pfp_vtx_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pfp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mag_of(opa)),
      .b     (mag_of(opb)),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pfp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len1_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   pfp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sq_rad),
      .done  (sq_done),
      .root  (sq_root)
   );

endmodule
